// File: hw/rtl/gcpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpt_pkg
// Shared types and constants of the gain compression point tracker.
// ----------------------------------------------------------------------------
package gcpt_pkg;

    // field widths fixed by the item format
    localparam int BIN_W      = 10;
    localparam int BIN_SPAN   = 1 << BIN_W;
    localparam int VAL_W      = 16;
    localparam int POUT_W     = VAL_W + 1;
    localparam int LEVEL_W    = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LEVEL_W;
    localparam int BIN_CMP_W  = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSION_LEVEL   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_EXPANSION_MODE = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 15'd256;

    // interpolation divider: 34 bit dividend, two quotient bits a cycle
    localparam int DIV_W     = 34;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    // per bin record held in the state memory
    typedef struct packed {
        logic signed [VAL_W-1:0] peak_gain;
        logic signed [VAL_W-1:0] peak_pin;
        logic signed [VAL_W-1:0] last_gain;
        logic signed [VAL_W-1:0] last_power;
        logic                    flag;
        logic signed [VAL_W-1:0] comp_pin;
        logic signed [VAL_W-1:0] comp_gain;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic eval;
        logic mul;
        logic load;
        logic div_step;
        logic fin;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic interp;
    } t_status;

endpackage

// File: hw/rtl/gcpt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpt_in_if
// Measurement channel: valid/ready handshake with one gain measurement.
// ----------------------------------------------------------------------------
interface gcpt_in_if;
    logic                 valid;
    logic                 ready;
    logic                 first_sweep;
    logic [9:0]           bin_index;
    logic signed [15:0]   drive_power;
    logic signed [15:0]   measured_gain;

    modport source (
        output valid, first_sweep, bin_index, drive_power, measured_gain,
        input  ready
    );
    modport sink (
        input  valid, first_sweep, bin_index, drive_power, measured_gain,
        output ready
    );
endinterface

// File: hw/rtl/gcpt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpt_out_if
// Result channel: valid/ready handshake with the per bin compression result.
// ----------------------------------------------------------------------------
interface gcpt_out_if;
    logic                 valid;
    logic                 ready;
    logic [9:0]           out_bin;
    logic                 is_compressed;
    logic signed [15:0]   pin_at_compression;
    logic signed [15:0]   gain_at_compression;
    logic signed [16:0]   pout_at_compression;
    logic signed [15:0]   peak_gain;
    logic signed [15:0]   pin_at_peak_gain;
    logic signed [16:0]   pout_at_peak_gain;

    modport source (
        output valid, out_bin, is_compressed, pin_at_compression, gain_at_compression,
               pout_at_compression, peak_gain, pin_at_peak_gain, pout_at_peak_gain,
        input  ready
    );
    modport sink (
        input  valid, out_bin, is_compressed, pin_at_compression, gain_at_compression,
               pout_at_compression, peak_gain, pin_at_peak_gain, pout_at_peak_gain,
        output ready
    );
endinterface

// File: hw/rtl/gain_compression_point_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_compression_point_tracker_top
// Per bin peak gain and compression point tracking of amplifier sweeps.
//
//   channel   dir   handshake      payload
//   i_in      in    valid/ready    first_sweep, bin_index, drive_power,
//                                  measured_gain
//   o_out     out   valid/ready    out_bin, is_compressed, compression and
//                                  peak gain fields
//   i_cfg_*   in    write enable   register index, write data
//
// A transaction passes through read, evaluate and write back before the next
// is accepted; the one that finds the compression point also passes through
// multiply, divider load, the serial divider steps (two quotient bits each)
// and a finishing step. One transaction is in flight at a time; the state
// memory is read once and written at most once per transaction.
// The result register holds while o_out is stalled; a further transaction is
// accepted meanwhile and waits at write back until the result is taken.
// Reset clears control and configuration only; bin records are undefined
// until a first sweep writes them.
// ----------------------------------------------------------------------------
module gain_compression_point_tracker_top #(
    parameter int MAX_BINS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    gcpt_in_if.sink                          i_in,
    gcpt_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [gcpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gcpt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    gcpt_pkg::t_cmd    cmd;
    gcpt_pkg::t_status status;

    gcpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gcpt_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_first_sweep         (i_in.first_sweep),
        .i_bin_index           (i_in.bin_index),
        .i_drive_power         (i_in.drive_power),
        .i_measured_gain       (i_in.measured_gain),
        .i_cmd                 (cmd),
        .o_status              (status),
        .o_out_bin             (o_out.out_bin),
        .o_is_compressed       (o_out.is_compressed),
        .o_pin_at_compression  (o_out.pin_at_compression),
        .o_gain_at_compression (o_out.gain_at_compression),
        .o_pout_at_compression (o_out.pout_at_compression),
        .o_peak_gain           (o_out.peak_gain),
        .o_pin_at_peak_gain    (o_out.pin_at_peak_gain),
        .o_pout_at_peak_gain   (o_out.pout_at_peak_gain)
    );

endmodule

// File: hw/rtl/gcpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/gcpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpt_ctrl
// Sequencer: read, evaluate, optional interpolation divide, write back.
// ----------------------------------------------------------------------------
module gcpt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  gcpt_pkg::t_status   i_status,
    output gcpt_pkg::t_cmd      o_cmd
);

    gcpt_pkg::t_state           r_state;
    gcpt_pkg::t_state           n_state;
    logic [gcpt_pkg::CNT_W-1:0] r_cnt;
    logic [gcpt_pkg::CNT_W-1:0] n_cnt;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic                       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gcpt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = gcpt_pkg::S_READ;
            end
            gcpt_pkg::S_READ: n_state = gcpt_pkg::S_EVAL;
            gcpt_pkg::S_EVAL: begin
                n_state = i_status.interp ? gcpt_pkg::S_MUL : gcpt_pkg::S_DONE;
            end
            gcpt_pkg::S_MUL:  n_state = gcpt_pkg::S_LOAD;
            gcpt_pkg::S_LOAD: n_state = gcpt_pkg::S_DIV;
            gcpt_pkg::S_DIV: begin
                if (r_cnt == gcpt_pkg::CNT_LAST) n_state = gcpt_pkg::S_FIN;
            end
            gcpt_pkg::S_FIN:  n_state = gcpt_pkg::S_DONE;
            gcpt_pkg::S_DONE: begin
                if (out_free) n_state = gcpt_pkg::S_IDLE;
            end
            default: n_state = gcpt_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            gcpt_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.capture  = i_in_valid;
            end
            gcpt_pkg::S_READ: ;
            gcpt_pkg::S_EVAL: o_cmd.eval     = 1'b1;
            gcpt_pkg::S_MUL:  o_cmd.mul      = 1'b1;
            gcpt_pkg::S_LOAD: o_cmd.load     = 1'b1;
            gcpt_pkg::S_DIV:  o_cmd.div_step = 1'b1;
            gcpt_pkg::S_FIN:  o_cmd.fin      = 1'b1;
            gcpt_pkg::S_DONE: o_cmd.commit   = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (r_state == gcpt_pkg::S_LOAD) begin
            n_cnt = '0;
        end else if (r_state == gcpt_pkg::S_DIV) begin
            n_cnt = r_cnt + 1'b1;
        end
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gcpt_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_in_ready)
        else $error("second transaction taken while one is in flight");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gcpt_pkg::S_DIV) |-> (r_cnt <= gcpt_pkg::CNT_LAST))
        else $error("divider step count out of range");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == gcpt_pkg::S_DONE))
        else $error("result raised outside write back");
`endif

endmodule

// File: hw/rtl/gcpt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpt_dp
// Datapath: config registers, per bin state memory, update logic and the
// radix-4 restoring divider used for the compression point interpolation.
// ----------------------------------------------------------------------------
module gcpt_dp #(
    parameter int MAX_BINS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gcpt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gcpt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_first_sweep,
    input  logic [gcpt_pkg::BIN_W-1:0]          i_bin_index,
    input  logic signed [gcpt_pkg::VAL_W-1:0]   i_drive_power,
    input  logic signed [gcpt_pkg::VAL_W-1:0]   i_measured_gain,
    input  gcpt_pkg::t_cmd                      i_cmd,
    output gcpt_pkg::t_status                   o_status,
    output logic [gcpt_pkg::BIN_W-1:0]          o_out_bin,
    output logic                                o_is_compressed,
    output logic signed [gcpt_pkg::VAL_W-1:0]   o_pin_at_compression,
    output logic signed [gcpt_pkg::VAL_W-1:0]   o_gain_at_compression,
    output logic signed [gcpt_pkg::POUT_W-1:0]  o_pout_at_compression,
    output logic signed [gcpt_pkg::VAL_W-1:0]   o_peak_gain,
    output logic signed [gcpt_pkg::VAL_W-1:0]   o_pin_at_peak_gain,
    output logic signed [gcpt_pkg::POUT_W-1:0]  o_pout_at_peak_gain
);

    localparam int DEPTH = (MAX_BINS < gcpt_pkg::BIN_SPAN) ? MAX_BINS : gcpt_pkg::BIN_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = $bits(gcpt_pkg::t_entry);
    localparam logic [gcpt_pkg::BIN_CMP_W-1:0] BIN_LIMIT = gcpt_pkg::BIN_CMP_W'(MAX_BINS);

    // configuration
    logic [gcpt_pkg::LEVEL_W-1:0] r_level;
    logic                         r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= gcpt_pkg::LEVEL_RESET;
            r_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gcpt_pkg::CFG_COMPRESSION_LEVEL:   r_level <= i_cfg_data;
                gcpt_pkg::CFG_GAIN_EXPANSION_MODE: r_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // captured transaction
    logic                             r_first;
    logic [gcpt_pkg::BIN_W-1:0]       r_bin;
    logic signed [gcpt_pkg::VAL_W-1:0] r_p;
    logic signed [gcpt_pkg::VAL_W-1:0] r_g;
    logic                             oor;

    assign oor = {{(gcpt_pkg::BIN_CMP_W - gcpt_pkg::BIN_W){1'b0}}, r_bin} >= BIN_LIMIT;

    // state memory
    logic [EW-1:0]          ram_rdata;
    gcpt_pkg::t_entry       r_new;
    logic                   ram_we;

    assign ram_we = i_cmd.commit && !oor;

    gcpt_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_bin[AW-1:0]),
        .i_wdata (r_new),
        .i_raddr (r_bin[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // evaluation of the stored record against the new measurement
    gcpt_pkg::t_entry       e;
    gcpt_pkg::t_entry       upd;
    logic                   exp_up;
    logic signed [15:0]     pk;
    logic signed [15:0]     pp;
    logic                   fl;
    logic signed [16:0]     thr;
    logic signed [16:0]     g17;
    logic                   hit;
    logic signed [15:0]     thr_sat;
    logic signed [16:0]     den;
    logic signed [17:0]     dy;
    logic signed [16:0]     dx;
    logic [15:0]            den_abs;
    logic                   interp;

    always_comb begin
        e       = gcpt_pkg::t_entry'(ram_rdata);
        exp_up  = r_mode && (e.peak_gain < r_g);
        pk      = exp_up ? r_g : e.peak_gain;
        pp      = exp_up ? r_p : e.peak_pin;
        fl      = exp_up ? 1'b0 : e.flag;
        thr     = $signed({pk[15], pk}) - $signed({2'b00, r_level});
        g17     = $signed({r_g[15], r_g});
        hit     = !fl && (g17 <= thr);
        // threshold can only run off the negative end
        thr_sat = (thr[16] != thr[15]) ? 16'sh8000 : thr[15:0];
        den     = g17 - $signed({e.last_gain[15], e.last_gain});
        dy      = $signed({thr[16], thr}) - $signed({{2{e.last_gain[15]}}, e.last_gain});
        dx      = $signed({r_p[15], r_p}) - $signed({e.last_power[15], e.last_power});
        den_abs = den[16] ? 16'(-den) : den[15:0];
        interp  = !oor && !r_first && hit && (den != 17'sd0);

        upd.last_gain  = r_g;
        upd.last_power = r_p;
        if (r_first) begin
            upd.peak_gain = r_g;
            upd.peak_pin  = r_p;
            upd.flag      = 1'b0;
            upd.comp_pin  = r_p;
            upd.comp_gain = r_g;
        end else begin
            upd.peak_gain = pk;
            upd.peak_pin  = pp;
            upd.flag      = fl || hit;
            upd.comp_pin  = fl ? e.comp_pin : r_p;
            upd.comp_gain = fl ? e.comp_gain : (hit ? thr_sat : r_g);
        end
    end

    assign o_status.interp = interp;

    // interpolation arithmetic
    logic signed [17:0]     r_dy;
    logic signed [16:0]     r_dx;
    logic [15:0]            r_den_abs;
    logic                   r_den_neg;
    logic signed [15:0]     r_x0;
    logic signed [34:0]     r_prod;
    logic                   r_neg;
    logic [gcpt_pkg::DIV_W-1:0] r_quo;
    logic [15:0]            r_rem;

    logic [34:0]            prod_abs;
    logic [gcpt_pkg::DIV_W-1:0] dividend;
    logic [15:0]            rem_nx;
    logic [gcpt_pkg::DIV_W-1:0] quo_nx;
    logic [16:0]            trial;
    logic [16:0]            qc;
    logic signed [17:0]     qs;
    logic signed [18:0]     xsum;
    logic signed [15:0]     x_sat;

    always_comb begin
        prod_abs = r_prod[34] ? 35'(-r_prod) : 35'(r_prod);
        dividend = prod_abs[gcpt_pkg::DIV_W-1:0]
                 + {{(gcpt_pkg::DIV_W - 16){1'b0}}, (r_den_abs >> 1)};

        // two restoring steps per cycle
        rem_nx = r_rem;
        quo_nx = r_quo;
        for (int k = 0; k < 2; k++) begin
            trial  = {rem_nx, quo_nx[gcpt_pkg::DIV_W-1]};
            quo_nx = {quo_nx[gcpt_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den_abs}) begin
                rem_nx    = 16'(trial - {1'b0, r_den_abs});
                quo_nx[0] = 1'b1;
            end else begin
                rem_nx = trial[15:0];
            end
        end

        // a quotient beyond 17 bits saturates either way, so clamp it early
        qc    = (|r_quo[gcpt_pkg::DIV_W-1:17]) ? 17'h10000 : r_quo[16:0];
        qs    = r_neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        xsum  = $signed({{3{r_x0[15]}}, r_x0}) + $signed({qs[17], qs});
        if (xsum > 19'sd32767) begin
            x_sat = 16'sh7fff;
        end else if (xsum < -19'sd32768) begin
            x_sat = 16'sh8000;
        end else begin
            x_sat = xsum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_first <= i_first_sweep;
            r_bin   <= i_bin_index;
            r_p     <= i_drive_power;
            r_g     <= i_measured_gain;
        end
        if (i_cmd.eval) begin
            r_new     <= upd;
            r_dy      <= dy;
            r_dx      <= dx;
            r_den_abs <= den_abs;
            r_den_neg <= den[16];
            r_x0      <= e.last_power;
        end
        if (i_cmd.mul) begin
            r_prod <= r_dy * r_dx;
        end
        if (i_cmd.load) begin
            r_neg <= r_prod[34] ^ r_den_neg;
            r_quo <= dividend;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= quo_nx;
            r_rem <= rem_nx;
        end
        if (i_cmd.fin) begin
            r_new.comp_pin <= x_sat;
        end
        if (i_cmd.commit) begin
            o_out_bin <= r_bin;
            if (oor) begin
                o_is_compressed       <= 1'b0;
                o_pin_at_compression  <= '0;
                o_gain_at_compression <= '0;
                o_pout_at_compression <= '0;
                o_peak_gain           <= '0;
                o_pin_at_peak_gain    <= '0;
                o_pout_at_peak_gain   <= '0;
            end else begin
                o_is_compressed       <= r_new.flag;
                o_pin_at_compression  <= r_new.comp_pin;
                o_gain_at_compression <= r_new.comp_gain;
                o_pout_at_compression <= $signed({r_new.comp_pin[15], r_new.comp_pin})
                                       + $signed({r_new.comp_gain[15], r_new.comp_gain});
                o_peak_gain           <= r_new.peak_gain;
                o_pin_at_peak_gain    <= r_new.peak_pin;
                o_pout_at_peak_gain   <= $signed({r_new.peak_pin[15], r_new.peak_pin})
                                       + $signed({r_new.peak_gain[15], r_new.peak_gain});
            end
        end
    end

`ifndef SYNTHESIS
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_den_abs != 16'd0))
        else $error("interpolation divide with zero slope");
`endif

endmodule

// File: sim/tb_gain_compression_point_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gain_compression_point_tracker_top
// Self-checking bench for the per bin peak gain and compression point tracker.
// A scoreboard class predicts each result from the accepted measurement and
// the register settings, and compares it with what the block returns. The
// stimulus is a short directed part followed by interleaved power sweeps
// with random content, some noise, bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_gain_compression_point_tracker_top;
    import gcpt_pkg::*;

    localparam int TRACKED_BINS    = 1024;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int N_PHASES        = 8;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_AT         = 600;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int N_SLOTS         = 4;

    typedef struct {
        logic [BIN_W-1:0]        bin;
        logic                    compressed;
        logic signed [VAL_W-1:0] comp_pin;
        logic signed [VAL_W-1:0] comp_gain;
        logic signed [VAL_W:0]   comp_pout;
        logic signed [VAL_W-1:0] peak_gain;
        logic signed [VAL_W-1:0] peak_pin;
        logic signed [VAL_W:0]   peak_pout;
    } t_point_result;

    class compression_scoreboard;
        int  level;
        bit  expansion_on;
        int  mismatches;
        int  peak_gain_by_bin[TRACKED_BINS];
        int  peak_pin_by_bin[TRACKED_BINS];
        int  last_gain_by_bin[TRACKED_BINS];
        int  last_power_by_bin[TRACKED_BINS];
        bit  compressed_by_bin[TRACKED_BINS];
        int  comp_pin_by_bin[TRACKED_BINS];
        int  comp_gain_by_bin[TRACKED_BINS];
        t_point_result pending_points[$];

        function new();
            level        = LEVEL_RESET;
            expansion_on = 1'b0;
            mismatches   = 0;
        endfunction

        static function int clip16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return int'(v);
        endfunction

        // drive power where the segment between the two points crosses the threshold
        static function int interp_power(int x0, int y0, int x1, int y1, longint y);
            longint num;
            longint den;
            longint q;
            num = (y - y0) * (longint'(x1) - x0);
            den = longint'(y1) - y0;
            if (den == 0) return x1;
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            // round to nearest, ties away from zero
            if (num >= 0) q = (num + den / 2) / den;
            else q = -((-num + den / 2) / den);
            return clip16(longint'(x0) + q);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, int value);
            case (idx)
                CFG_COMPRESSION_LEVEL:   level = value & 32'h7fff;
                CFG_GAIN_EXPANSION_MODE: expansion_on = value[0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_points.size();
        endfunction

        function void note_measurement(bit first, logic [BIN_W-1:0] b,
                                       logic signed [VAL_W-1:0] p,
                                       logic signed [VAL_W-1:0] g);
            t_point_result r;
            longint thr;
            int pw;
            int gn;
            pw = p;
            gn = g;
            r = '{default: '0};
            r.bin = b;
            if (b >= TRACKED_BINS) begin
                pending_points.push_back(r);
                return;
            end
            if (first) begin
                peak_gain_by_bin[b]  = gn;
                peak_pin_by_bin[b]   = pw;
                compressed_by_bin[b] = 1'b0;
                comp_pin_by_bin[b]   = pw;
                comp_gain_by_bin[b]  = gn;
            end else begin
                if (expansion_on && peak_gain_by_bin[b] < gn) begin
                    peak_gain_by_bin[b]  = gn;
                    peak_pin_by_bin[b]   = pw;
                    compressed_by_bin[b] = 1'b0;
                end
                thr = longint'(peak_gain_by_bin[b]) - level;
                if (!compressed_by_bin[b]) begin
                    if (gn <= thr) begin
                        comp_pin_by_bin[b] = interp_power(last_power_by_bin[b],
                                                          last_gain_by_bin[b], pw, gn, thr);
                        comp_gain_by_bin[b]  = clip16(thr);
                        compressed_by_bin[b] = 1'b1;
                    end else begin
                        comp_pin_by_bin[b]  = pw;
                        comp_gain_by_bin[b] = gn;
                    end
                end
            end
            last_gain_by_bin[b]  = gn;
            last_power_by_bin[b] = pw;

            r.compressed = compressed_by_bin[b];
            r.comp_pin   = comp_pin_by_bin[b];
            r.comp_gain  = comp_gain_by_bin[b];
            r.comp_pout  = comp_pin_by_bin[b] + comp_gain_by_bin[b];
            r.peak_gain  = peak_gain_by_bin[b];
            r.peak_pin   = peak_pin_by_bin[b];
            r.peak_pout  = peak_pin_by_bin[b] + peak_gain_by_bin[b];
            pending_points.push_back(r);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            mismatches++;
            if (mismatches <= 20)
                $display("mismatch: %s got %0d expected %0d", what, got, want);
        endtask

        task check_result(t_point_result got);
            t_point_result want;
            if (pending_points.size() == 0) begin
                report_mismatch("result with no transaction pending, bin", got.bin, -1);
                return;
            end
            want = pending_points.pop_front();
            if (got.bin !== want.bin)
                report_mismatch("out_bin", got.bin, want.bin);
            if (got.compressed !== want.compressed)
                report_mismatch("is_compressed", got.compressed, want.compressed);
            if (got.comp_pin !== want.comp_pin)
                report_mismatch("pin_at_compression", got.comp_pin, want.comp_pin);
            if (got.comp_gain !== want.comp_gain)
                report_mismatch("gain_at_compression", got.comp_gain, want.comp_gain);
            if (got.comp_pout !== want.comp_pout)
                report_mismatch("pout_at_compression", got.comp_pout, want.comp_pout);
            if (got.peak_gain !== want.peak_gain)
                report_mismatch("peak_gain", got.peak_gain, want.peak_gain);
            if (got.peak_pin !== want.peak_pin)
                report_mismatch("pin_at_peak_gain", got.peak_pin, want.peak_pin);
            if (got.peak_pout !== want.peak_pout)
                report_mismatch("pout_at_peak_gain", got.peak_pout, want.peak_pout);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gcpt_in_if  in_ch ();
    gcpt_out_if out_ch ();

    gain_compression_point_tracker_top #(
        .MAX_BINS (TRACKED_BINS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    compression_scoreboard sb;
    int measurements_taken = 0;
    int cycle_count = 0;

    // bins that a first sweep has written; only these are swept further
    bit bin_written[TRACKED_BINS];
    int written_bins[$];

    // interleaved sweeps in progress
    logic [BIN_W-1:0] slot_bin[N_SLOTS];
    int slot_pow[N_SLOTS];
    int slot_gain[N_SLOTS];
    int slot_left[N_SLOTS];
    int slot_knee[N_SLOTS];
    int slot_step[N_SLOTS];

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // transaction monitors
    always @(posedge i_clk) begin
        t_point_result r;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            sb.note_measurement(in_ch.first_sweep, in_ch.bin_index,
                                in_ch.drive_power, in_ch.measured_gain);
            measurements_taken++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            r.bin        = out_ch.out_bin;
            r.compressed = out_ch.is_compressed;
            r.comp_pin   = out_ch.pin_at_compression;
            r.comp_gain  = out_ch.gain_at_compression;
            r.comp_pout  = out_ch.pout_at_compression;
            r.peak_gain  = out_ch.peak_gain;
            r.peak_pin   = out_ch.pin_at_peak_gain;
            r.peak_pout  = out_ch.pout_at_peak_gain;
            sb.check_result(r);
        end
    end

    // receiver: changing stall patterns, plus one long hold-off
    initial begin
        int rx_mode;
        int rx_left;
        bit hold_done;
        rx_mode   = 0;
        rx_left   = 0;
        hold_done = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && measurements_taken >= HOLD_AT) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            case (rx_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= $urandom_range(0, 1);
                2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= (rx_left % 8 == 0);
            endcase
        end
    end

    task automatic offer_measurement(bit first, logic [BIN_W-1:0] b,
                                     logic signed [VAL_W-1:0] p,
                                     logic signed [VAL_W-1:0] g);
        if (first && !bin_written[b]) begin
            bin_written[b] = 1'b1;
            written_bins.push_back(b);
        end
        in_ch.valid         <= 1'b1;
        in_ch.first_sweep   <= first;
        in_ch.bin_index     <= b;
        in_ch.drive_power   <= p;
        in_ch.measured_gain <= g;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic idle_input(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        sb.set_register(idx, value);
        @(negedge i_clk);
    endtask

    task automatic set_registers(int level, bit expansion);
        write_register(CFG_COMPRESSION_LEVEL, level);
        write_register(CFG_GAIN_EXPANSION_MODE, int'(expansion));
        i_cfg_we <= 1'b0;
    endtask

    // next point: mostly a step of some running sweep, now and then noise
    task automatic make_point(output bit first, output logic [BIN_W-1:0] b,
                              output logic signed [VAL_W-1:0] p,
                              output logic signed [VAL_W-1:0] g);
        int s;
        int dg;
        if ($urandom_range(0, 99) < 12) begin
            if ($urandom_range(0, 1) == 1 || written_bins.size() == 0) begin
                first = 1'b1;
                b     = $urandom_range(0, TRACKED_BINS - 1);
            end else begin
                first = 1'b0;
                b     = written_bins[$urandom_range(0, written_bins.size() - 1)];
            end
            p = $urandom;
            g = $urandom;
        end else begin
            s = $urandom_range(0, N_SLOTS - 1);
            if (slot_left[s] == 0) begin
                slot_bin[s]  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TRACKED_BINS - 1)
                                                           : $urandom_range(0, 15);
                slot_pow[s]  = int'($urandom_range(0, 8000)) - 6000;
                slot_gain[s] = int'($urandom_range(0, 8000)) - 2000;
                slot_left[s] = $urandom_range(4, 24);
                slot_knee[s] = $urandom_range(0, slot_left[s] - 1);
                slot_step[s] = $urandom_range(32, 768);
                first = 1'b1;
            end else begin
                slot_left[s]--;
                // roughly flat before the knee (small steps either way), falling after it
                if (slot_left[s] > slot_knee[s]) dg = int'($urandom_range(0, 96)) - 32;
                else dg = -int'($urandom_range(16, 400));
                slot_pow[s]  = compression_scoreboard::clip16(slot_pow[s] + slot_step[s]);
                slot_gain[s] = compression_scoreboard::clip16(slot_gain[s] + dg);
                first = 1'b0;
            end
            b = slot_bin[s];
            p = slot_pow[s];
            g = slot_gain[s];
        end
    endtask

    initial begin
        int phase_level[N_PHASES] = '{32767, 0, 256, -1, 1, -1, 32767, 256};
        int phase_mode[N_PHASES]  = '{0, 1, 1, 0, 1, 2, 1, 0};
        int n;
        int burst;
        int lvl;
        bit mode;
        bit f;
        logic [BIN_W-1:0] b;
        logic signed [VAL_W-1:0] p;
        logic signed [VAL_W-1:0] g;

        sb = new();
        for (int k = 0; k < N_SLOTS; k++) slot_left[k] = 0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.first_sweep   = 1'b0;
        in_ch.bin_index     = '0;
        in_ch.drive_power   = '0;
        in_ch.measured_gain = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults: 1 dB level, no expansion
        offer_measurement(1'b1, 10'd0, 16'sd0, 16'sd0);
        offer_measurement(1'b0, 10'd0, 16'sd256, 16'sd0);
        offer_measurement(1'b0, 10'd0, 16'sd512, -16'sd256);    // lands exactly on threshold
        offer_measurement(1'b0, 10'd0, 16'sd768, -16'sd1000);   // already compressed
        offer_measurement(1'b1, 10'd1023, -16'sd32768, 16'sd32767);
        offer_measurement(1'b0, 10'd1023, 16'sd32767, -16'sd32768);
        offer_measurement(1'b1, 10'd2, 16'sd0, 16'sd0);
        offer_measurement(1'b0, 10'd2, 16'sd1, -16'sd512);      // half-way tie, rising power
        offer_measurement(1'b1, 10'd3, 16'sd1, 16'sd0);
        offer_measurement(1'b0, 10'd3, 16'sd0, -16'sd512);      // half-way tie, falling power
        offer_measurement(1'b1, 10'd512, 16'sd32767, -16'sd32768);
        offer_measurement(1'b0, 10'd512, -16'sd32768, -16'sd32768);
        offer_measurement(1'b0, 10'd0, 16'sd1024, 16'sd5000);   // rise ignored without expansion
        offer_measurement(1'b1, 10'h155, -16'sd1, -16'sd1);
        offer_measurement(1'b1, 10'h2aa, 16'sh5555, 16'sh2aaa);
        wait_for_results();

        // zero level: equal gains give no slope
        set_registers(0, 1'b1);
        offer_measurement(1'b1, 10'd4, 16'sd100, 16'sd200);
        offer_measurement(1'b0, 10'd4, 16'sd200, 16'sd200);
        offer_measurement(1'b0, 10'd4, 16'sd300, 16'sd500);
        wait_for_results();

        // expansion lifts the peak and clears the compressed mark
        set_registers(256, 1'b1);
        offer_measurement(1'b0, 10'd0, 16'sd1280, 16'sd6000);
        offer_measurement(1'b0, 10'd0, 16'sd1536, 16'sd5800);
        offer_measurement(1'b0, 10'd0, 16'sd1792, 16'sd5000);
        offer_measurement(1'b1, 10'd5, 16'sd0, -16'sd32768);
        offer_measurement(1'b0, 10'd5, 16'sd10, 16'sd32767);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_for_results();
            lvl  = (phase_level[ph] < 0) ? $urandom_range(0, 1024) : phase_level[ph];
            mode = (phase_mode[ph] > 1) ? $urandom_range(0, 1) : phase_mode[ph][0];
            set_registers(lvl, mode);
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 16);
                while (burst > 0 && n < ITEMS_PER_PHASE) begin
                    make_point(f, b, p, g);
                    offer_measurement(f, b, p, g);
                    burst--;
                    n++;
                end
                if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
            end
        end
        wait_for_results();

        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
